// ===== rtl/sprite_quad_setup_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sprite quad setup assertion macros
// Shared concurrent assertion forms, clocked on aclk, off during reset.
// ----------------------------------------------------------------------------
`ifndef SPRITE_QUAD_SETUP_CORE_DEFINES_SVH
`define SPRITE_QUAD_SETUP_CORE_DEFINES_SVH

// condition holds at every edge out of reset
`define SQS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// consequent holds at the next edge after the antecedent
`define SQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup package
// Item types, register indexes, tile divider links and sine table maths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sqs_pkg;

    localparam int SINE_TABLE_BITS_DEF = 10;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int SW_W       = 13;
    localparam int TW_W       = 14;

    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_WIDTH = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANIMATED      = 8'd3;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        frame_number;
        logic signed [15:0] handle_x;
        logic signed [15:0] handle_y;
        logic [15:0]        angle;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         opacity;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic               last_corner;
        logic signed [23:0] vertex_x;
        logic signed [23:0] vertex_y;
        logic [15:0]        tex_u;
        logic [15:0]        tex_v;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic [7:0]         out_opacity;
    } out_item_t;

    typedef struct packed {
        logic            start;
        logic [TW_W-1:0] dividend;
        logic [SW_W-1:0] divisor;
    } tile_req_t;

    typedef struct packed {
        logic            busy;
        logic [TW_W-1:0] tiles;
    } tile_stat_t;

    // truncating quotient of non-negative values by shift and subtract
    function automatic longint trunc_div(input longint num, input longint den);
        longint q;
        longint r;
        int b;
        q = 0;
        r = 0;
        for (b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & 64'sd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'sd1 <<< b);
            end
        end
        return q;
    endfunction

    // sin(p/q * pi/2), 14 fraction bits, q = 2^(bits-2)
    function automatic logic [14:0] quarter_sine(input longint p, input int bits);
        longint x;
        longint x2;
        longint term;
        longint sum;
        longint r;
        int n;
        x = (p * HALF_PI_Q30) >>> (bits - 2);
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (n = 1; n <= 7; n++) begin
            term = trunc_div((term * x2) >>> 30, longint'((2 * n) * (2 * n + 1)));
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        r = (sum + 32768) >>> 16;
        if (r > 16384) begin
            r = 16384;
        end
        return r[14:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sqs_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup quarter sine table
// Two registered read ports on a quarter wave table built at elaboration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sqs_sine_rom
    import sqs_pkg::*;
#(
    parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic [TABLE_BITS-2:0] sin_addr,
    input  wire logic [TABLE_BITS-2:0] cos_addr,
    output logic      [14:0]           sin_mag,
    output logic      [14:0]           cos_mag
);

    localparam int Q = 1 << (TABLE_BITS - 2);

    typedef logic [14:0] rom_t [0:Q];

    function automatic rom_t build_rom();
        rom_t t;
        for (int p = 0; p <= Q; p++) begin
            t[p] = quarter_sine(longint'(p), TABLE_BITS);
        end
        return t;
    endfunction

    localparam rom_t ROM = build_rom();

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_mag <= ROM[sin_addr];
            cos_mag <= ROM[cos_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sqs_tile_div.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup tile divider
// Tiles per row from sheet and frame width, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_quad_setup_core_defines.svh"

module sqs_tile_div
    import sqs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire tile_req_t  req,
    output tile_stat_t      stat
);

    logic            busy_reg;
    logic [3:0]      cnt_reg;
    logic [TW_W-1:0] num_reg;
    logic [SW_W-1:0] den_reg;
    logic [TW_W-1:0] rem_reg;
    logic [TW_W-1:0] quo_reg;
    logic [TW_W-1:0] tiles_reg;

    logic [TW_W:0]   trial;
    logic            ge;
    logic [TW_W-1:0] rem_next;
    logic [TW_W-1:0] quo_next;

    always_comb begin
        trial = {rem_reg, num_reg[TW_W-1]};
        ge = trial >= {2'b00, den_reg};
        rem_next = ge ? TW_W'(trial - {2'b00, den_reg}) : trial[TW_W-1:0];
        quo_next = {quo_reg[TW_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            cnt_reg   <= 4'd0;
            tiles_reg <= TW_W'(1);
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 4'd1;
            if (cnt_reg == 4'(TW_W - 1)) begin
                busy_reg  <= 1'b0;
                tiles_reg <= (quo_next == '0) ? TW_W'(1) : quo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.dividend;
            den_reg <= (req.divisor == '0) ? SW_W'(1) : req.divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[TW_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy  = busy_reg;
    assign stat.tiles = tiles_reg;

    `SQS_ASSERT_ALWAYS(a_tiles_nonzero, tiles_reg != '0, "tiles per row is zero")
    `SQS_ASSERT_NEXT(a_start_busy, req.start, busy_reg, "divider did not start")

endmodule

`default_nettype wire

// ===== rtl/sprite_quad_setup_core.sv =====
// ----------------------------------------------------------------------------
// Sprite quad setup core. The four-corner expander takes a new sprite only
// after the last corner of the one before; dropped sprites are not expanded.
// Frame tile division: 16-stage pipeline.
// After a sprite_width or texture_width write, input waits for the divider.
// Reset (aresetn low, synchronous) empties every stage, registers to reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sprite_quad_setup_core_defines.svh"

module sprite_quad_setup_core
    import sqs_pkg::*;
#(
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_item_t              s_item,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_item_t                  m_item,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int TB        = SINE_TABLE_BITS;
    localparam int AW        = TB - 1;
    localparam int Q         = 1 << (TB - 2);
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        frame_number;
        logic signed [15:0] handle_x;
        logic signed [15:0] handle_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [31:0]        colour;
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
        logic [TW_W-1:0]    rem;
        logic [15:0]        quo;
    } rec_t;

    typedef struct packed {
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic signed [15:0] handle_x;
        logic signed [15:0] handle_y;
        logic signed [15:0] scale_x;
        logic signed [15:0] scale_y;
        logic [31:0]        colour;
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
        logic [26:0]        uoff;
        logic [28:0]        voff;
    } spr_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [34:0] sxl;
        logic signed [34:0] syl;
        logic signed [15:0] sin_val;
        logic signed [15:0] cos_val;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        colour;
    } k1_t;

    typedef struct packed {
        logic [1:0]         corner;
        logic signed [50:0] p_xc;
        logic signed [50:0] p_ys;
        logic signed [50:0] p_xs;
        logic signed [50:0] p_yc;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_y;
        logic [15:0]        u;
        logic [15:0]        v;
        logic [31:0]        colour;
    } k2_t;

    // configuration
    logic [SW_W-1:0] sw_reg;
    logic [SW_W-1:0] sh_reg;
    logic [TW_W-1:0] tw_reg;
    logic            anim_reg;
    logic            cfg_fire;
    tile_req_t       tile_req;
    tile_stat_t      tile_stat;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg   <= SW_W'(16);
            sh_reg   <= SW_W'(16);
            tw_reg   <= TW_W'(16);
            anim_reg <= 1'b0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_SPRITE_WIDTH:  sw_reg   <= cfg_data[SW_W-1:0];
                REG_SPRITE_HEIGHT: sh_reg   <= cfg_data[SW_W-1:0];
                REG_TEXTURE_WIDTH: tw_reg   <= cfg_data[TW_W-1:0];
                REG_ANIMATED:      anim_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        tile_req.start = cfg_fire &&
            (cfg_index == REG_SPRITE_WIDTH || cfg_index == REG_TEXTURE_WIDTH);
        tile_req.dividend = (cfg_index == REG_TEXTURE_WIDTH) ? cfg_data[TW_W-1:0] : tw_reg;
        tile_req.divisor  = (cfg_index == REG_SPRITE_WIDTH) ? cfg_data[SW_W-1:0] : sw_reg;
    end

    sqs_tile_div u_tile_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tile_req),
        .stat    (tile_stat)
    );

    // stall control
    logic out_adv;
    logic front_adv;
    logic m_valid_reg;
    logic sp_valid_reg;
    logic [1:0] sp_cnt_reg;

    assign out_adv   = !m_valid_reg || m_ready;
    assign front_adv = out_adv && (!sp_valid_reg || sp_cnt_reg == CORNER_LAST);
    assign s_ready   = front_adv && !tile_stat.busy;

    // stage 0: input register
    logic     s0_valid_reg;
    in_item_t s0_item_reg;
    logic     drop;

    assign drop = (s_item.opacity == '0) || (s_item.scale_x == '0) || (s_item.scale_y == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (front_adv) begin
            s0_valid_reg <= s_valid && s_ready && !drop;
        end
    end

    always_ff @(posedge aclk) begin
        if (front_adv) begin
            s0_item_reg <= s_item;
        end
    end

    // sine table addressing
    function automatic logic [AW-1:0] rom_addr(input logic [TB-1:0] idx);
        logic [AW-1:0] p;
        p = {1'b0, idx[TB-3:0]};
        return idx[TB-2] ? (AW'(Q) - p) : p;
    endfunction

    logic [TB-1:0] sin_idx;
    logic [TB-1:0] cos_idx;
    logic [14:0]   sin_mag;
    logic [14:0]   cos_mag;

    assign sin_idx = s0_item_reg.angle[15 -: TB];
    assign cos_idx = sin_idx + TB'(Q);

    sqs_sine_rom #(
        .TABLE_BITS (TB)
    ) u_sine_rom (
        .aclk     (aclk),
        .en       (front_adv),
        .sin_addr (rom_addr(sin_idx)),
        .cos_addr (rom_addr(cos_idx)),
        .sin_mag  (sin_mag),
        .cos_mag  (cos_mag)
    );

    // stage 1: table data
    logic     s1_valid_reg;
    in_item_t s1_item_reg;
    logic     s1_sneg_reg;
    logic     s1_cneg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (front_adv) begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (front_adv) begin
            s1_item_reg <= s0_item_reg;
            s1_sneg_reg <= sin_idx[TB-1];
            s1_cneg_reg <= cos_idx[TB-1];
        end
    end

    rec_t rec0;

    always_comb begin
        rec0.pos_x        = s1_item_reg.pos_x;
        rec0.pos_y        = s1_item_reg.pos_y;
        rec0.frame_number = s1_item_reg.frame_number;
        rec0.handle_x     = s1_item_reg.handle_x;
        rec0.handle_y     = s1_item_reg.handle_y;
        rec0.scale_x      = s1_item_reg.scale_x;
        rec0.scale_y      = s1_item_reg.scale_y;
        rec0.colour       = {s1_item_reg.red, s1_item_reg.green,
                             s1_item_reg.blue, s1_item_reg.opacity};
        rec0.sin_val      = s1_sneg_reg ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
        rec0.cos_val      = s1_cneg_reg ? -signed'({1'b0, cos_mag}) : signed'({1'b0, cos_mag});
        rec0.rem          = '0;
        rec0.quo          = '0;
    end

    // frame / tiles, one quotient bit per stage
    logic d_valid_reg [DIV_STEPS];
    rec_t d_rec_reg   [DIV_STEPS];
    rec_t d_in        [DIV_STEPS];
    rec_t d_out       [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        logic [TW_W:0] trial;
        logic          ge;
        logic          vin;

        if (k == 0) begin : g_first
            assign d_in[k] = rec0;
            assign vin     = s1_valid_reg;
        end else begin : g_rest
            assign d_in[k] = d_rec_reg[k-1];
            assign vin     = d_valid_reg[k-1];
        end

        always_comb begin
            trial = {d_in[k].rem, d_in[k].frame_number[DIV_STEPS-1-k]};
            ge = trial >= {1'b0, tile_stat.tiles};
            d_out[k] = d_in[k];
            d_out[k].rem = ge ? TW_W'(trial - {1'b0, tile_stat.tiles}) : trial[TW_W-1:0];
            d_out[k].quo[DIV_STEPS-1-k] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                d_valid_reg[k] <= 1'b0;
            end else if (front_adv) begin
                d_valid_reg[k] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (front_adv) begin
                d_rec_reg[k] <= d_out[k];
            end
        end
    end

    // corner expander
    rec_t d_last;
    spr_t sp_next;
    spr_t sp_reg;

    assign d_last = d_rec_reg[DIV_STEPS-1];

    always_comb begin
        sp_next.pos_x    = d_last.pos_x;
        sp_next.pos_y    = d_last.pos_y;
        sp_next.handle_x = d_last.handle_x;
        sp_next.handle_y = d_last.handle_y;
        sp_next.scale_x  = d_last.scale_x;
        sp_next.scale_y  = d_last.scale_y;
        sp_next.colour   = d_last.colour;
        sp_next.sin_val  = d_last.sin_val;
        sp_next.cos_val  = d_last.cos_val;
        sp_next.uoff     = anim_reg ? 27'(d_last.rem * sw_reg) : '0;
        sp_next.voff     = anim_reg ? 29'(d_last.quo * sh_reg) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_valid_reg <= 1'b0;
            sp_cnt_reg   <= 2'd0;
        end else if (out_adv) begin
            if (sp_valid_reg) begin
                sp_cnt_reg <= sp_cnt_reg + 2'd1;
            end
            if (front_adv) begin
                sp_valid_reg <= d_valid_reg[DIV_STEPS-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (front_adv) begin
            sp_reg <= sp_next;
        end
    end

    // corner stage 1: local offset times scale
    logic               right;
    logic               bottom;
    logic signed [18:0] lx;
    logic signed [18:0] ly;
    logic [27:0]        u_sum;
    logic [29:0]        v_sum;
    k1_t                k1_next;
    k1_t                k1_reg;
    logic               k1_valid_reg;

    always_comb begin
        right  = sp_cnt_reg[1];
        bottom = sp_cnt_reg[1] ^ sp_cnt_reg[0];
        lx = signed'({2'b00, (right ? sw_reg : SW_W'(0)), 4'b0000}) - 19'(sp_reg.handle_x);
        ly = signed'({2'b00, (bottom ? sh_reg : SW_W'(0)), 4'b0000}) - 19'(sp_reg.handle_y);
        u_sum = 28'(sp_reg.uoff) + 28'(right ? sw_reg : SW_W'(0));
        v_sum = 30'(sp_reg.voff) + 30'(bottom ? sh_reg : SW_W'(0));
        k1_next.corner  = sp_cnt_reg;
        k1_next.sxl     = 35'(lx * sp_reg.scale_x);
        k1_next.syl     = 35'(ly * sp_reg.scale_y);
        k1_next.sin_val = sp_reg.sin_val;
        k1_next.cos_val = sp_reg.cos_val;
        k1_next.pos_x   = sp_reg.pos_x;
        k1_next.pos_y   = sp_reg.pos_y;
        k1_next.u       = (u_sum > 28'd65535) ? 16'hFFFF : u_sum[15:0];
        k1_next.v       = (v_sum > 30'd65535) ? 16'hFFFF : v_sum[15:0];
        k1_next.colour  = sp_reg.colour;
    end

    // corner stage 2: rotation products
    k2_t  k2_reg;
    logic k2_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_valid_reg <= 1'b0;
            k2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (out_adv) begin
            k1_valid_reg <= sp_valid_reg;
            k2_valid_reg <= k1_valid_reg;
            m_valid_reg  <= k2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            k1_reg        <= k1_next;
            k2_reg.corner <= k1_reg.corner;
            k2_reg.p_xc   <= 51'(k1_reg.sxl * k1_reg.cos_val);
            k2_reg.p_ys   <= 51'(k1_reg.syl * k1_reg.sin_val);
            k2_reg.p_xs   <= 51'(k1_reg.sxl * k1_reg.sin_val);
            k2_reg.p_yc   <= 51'(k1_reg.syl * k1_reg.cos_val);
            k2_reg.pos_x  <= k1_reg.pos_x;
            k2_reg.pos_y  <= k1_reg.pos_y;
            k2_reg.u      <= k1_reg.u;
            k2_reg.v      <= k1_reg.v;
            k2_reg.colour <= k1_reg.colour;
        end
    end

    // output stage: round, offset, saturate
    function automatic logic signed [23:0] sat24(input logic signed [35:0] v);
        if (v > 36'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -36'sd8388608) begin
            return 24'sh800000;
        end
        return v[23:0];
    endfunction

    logic signed [51:0] rx;
    logic signed [51:0] ry;
    logic signed [35:0] vx;
    logic signed [35:0] vy;
    out_item_t          m_item_next;
    out_item_t          m_item_reg;

    always_comb begin
        rx = 52'(k2_reg.p_xc) - 52'(k2_reg.p_ys) + 52'sd131072;
        ry = 52'(k2_reg.p_xs) + 52'(k2_reg.p_yc) + 52'sd131072;
        vx = 36'(rx >>> 18) + 36'(k2_reg.pos_x);
        vy = 36'(ry >>> 18) + 36'(k2_reg.pos_y);
        m_item_next.corner      = k2_reg.corner;
        m_item_next.last_corner = (k2_reg.corner == CORNER_LAST);
        m_item_next.vertex_x    = sat24(vx);
        m_item_next.vertex_y    = sat24(vy);
        m_item_next.tex_u       = k2_reg.u;
        m_item_next.tex_v       = k2_reg.v;
        m_item_next.out_red     = k2_reg.colour[31:24];
        m_item_next.out_green   = k2_reg.colour[23:16];
        m_item_next.out_blue    = k2_reg.colour[15:8];
        m_item_next.out_opacity = k2_reg.colour[7:0];
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_item_reg <= m_item_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    `SQS_ASSERT_NEXT(a_corner_run, m_valid && m_ready && !m_item.last_corner, m_valid && (m_item.corner == $past(m_item.corner) + 2'd1), "corner sequence broken")
    `SQS_ASSERT_ALWAYS(a_idle_count, sp_valid_reg || (sp_cnt_reg == 2'd0), "corner count moved while empty")
    `SQS_ASSERT_ALWAYS(a_busy_hold, !(tile_stat.busy && s_valid && s_ready), "item taken during tile divide")

endmodule

`default_nettype wire
